>>> hdl/sogi_pkg.sv
// Shared types and constants for the SOGI phase-locked loop.
// Holds the sequencer state type, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package sogi_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_OMEGA_REF = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OMEGA_MAX = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OMEGA_MIN = 3'd4;

    // Register reset values (Q20 rad/s)
    localparam logic [30:0] OMEGA_REF_RST = 31'd329420636;
    localparam logic [30:0] OMEGA_MAX_RST = 31'd362362700;
    localparam logic [30:0] OMEGA_MIN_RST = 31'd296478572;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 112;

    // Phase constants, Q20 rad
    localparam logic signed [23:0] PHASE_PI      = 24'sd3294206;
    localparam logic signed [23:0] PHASE_TWO_PI  = 24'sd6588413;
    localparam logic signed [23:0] PHASE_QUARTER = 24'sd1647100;

    // Parabolic sine coefficients
    localparam logic signed [32:0] K_PARA_SQ  = 33'sd415;
    localparam logic signed [32:0] K_PARA_LIN = 33'sd1304;
    localparam logic signed [32:0] K_REFINE   = 33'sd261;

    // Division by 16000: multiply by ceil(2^44/16000), keep bits 44 and up.
    // Exact for magnitudes up to 2^31.
    localparam logic signed [32:0] DIV_RECIP = 33'sd1099511628;
    localparam int DIV_SHIFT = 44;
    localparam int QUO_W     = 18;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_SIN_A, ST_SIN_B, ST_SIN_C, ST_SIN_D, ST_SIN_E,
        ST_SIN_F, ST_SIN_G, ST_SIN_H, ST_SIN_I,
        ST_DQ_A, ST_DQ_B, ST_DQ_C, ST_DQ_D, ST_DQ_E,
        ST_PI_A, ST_PI_B, ST_PI_C, ST_PI_D, ST_PI_E,
        ST_PH_A, ST_PH_B, ST_PH_C,
        ST_SG_A, ST_SG_B, ST_SG_C, ST_SG_D, ST_SG_E,
        ST_SG_F, ST_SG_G, ST_SG_H, ST_SG_I, ST_SG_J,
        ST_OUT
    } sogi_state_t;

endpackage

`default_nettype wire

>>> hdl/sogi_pll_fixed_point_top.sv
// Single-phase SOGI PLL, fixed point, built around one shared multiplier.
// Depends on sogi_pkg.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  grid_sample
//  m_*       out        m_tvalid/m_tready  volt_d, phase_out, omega_out, sine_out, cosine_out
//  cfg_*     in         cfg_we             register index and data, no read-back
//
// One item runs through 42 steps of the sequencer from accept to the next possible
// accept, most of them feeding or draining the single 33x33 multiplier (two sine
// passes of 9 steps, then d/q, PI, phase and SOGI updates).
// Reset (aresetn low, synchronous) clears the loop state and restores the
// register defaults. The result sits in an output register; the sequencer waits
// in its last step only if a new result is ready while the previous one is untaken.
`default_nettype none

module sogi_pll_fixed_point_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // grid_sample [11:0]
    input  wire logic [sogi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // volt_d [31:0], phase_out [54:32], omega_out [83:55],
    // sine_out [95:84], cosine_out [107:96]
    output logic [sogi_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_we,
    input  wire logic [sogi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [31:0]                      cfg_wdata
);
    import sogi_pkg::*;

    sogi_state_t state_reg, state_next;

    // Configuration
    logic [30:0]        omega_ref_reg, omega_max_reg, omega_min_reg;
    logic signed [31:0] gain_int_reg, gain_prop_reg;

    // Loop state
    logic signed [23:0] phase_acc_reg;
    logic signed [31:0] pi_integral_reg, beta_reg, sogi_one_reg, sogi_two_reg;

    // Working registers
    logic               cos_pass_reg;
    logic signed [11:0] g_reg;
    logic signed [23:0] th_reg, thc_reg, ph_tmp_reg;
    logic signed [31:0] sq_reg, y_reg, mag_reg, corr_reg, s_reg, c_reg;
    logic signed [31:0] acc_reg, vd_reg, qs_reg, w_reg;
    logic [31:0]        absx_reg;
    logic               neg_reg;
    logic signed [65:0] prod_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    // Derived values
    logic signed [31:0] prod_lo, t32, g32, bsh, wsh, neg_y, neg_prod, sin_sum, vq;
    logic signed [31:0] quo_s;
    logic [31:0]        abs_prod, quo32;
    logic [QUO_W-1:0]   quo;
    logic signed [23:0] thc_sum;
    logic               accept, out_load;

    assign prod_lo  = prod_reg[31:0];
    assign t32      = {{18{th_reg[23]}}, th_reg[23:10]};
    assign g32      = {{20{g_reg[11]}}, g_reg};
    assign bsh      = beta_reg >>> 10;
    assign wsh      = w_reg >>> 10;
    assign neg_y    = 32'sd0 - y_reg;
    assign neg_prod = 32'sd0 - prod_lo;
    assign abs_prod = prod_lo[31] ? neg_prod : prod_lo;
    assign sin_sum  = prod_lo + y_reg;
    assign vq       = acc_reg + prod_lo;
    assign quo      = prod_reg[DIV_SHIFT +: QUO_W];
    assign quo32    = {{(32-QUO_W){1'b0}}, quo};
    assign quo_s    = neg_reg ? (32'sd0 - $signed(quo32)) : $signed(quo32);
    assign thc_sum  = phase_acc_reg + PHASE_QUARTER;

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SIN_A;
            ST_SIN_A: state_next = ST_SIN_B;
            ST_SIN_B: state_next = ST_SIN_C;
            ST_SIN_C: state_next = ST_SIN_D;
            ST_SIN_D: state_next = ST_SIN_E;
            ST_SIN_E: state_next = ST_SIN_F;
            ST_SIN_F: state_next = ST_SIN_G;
            ST_SIN_G: state_next = ST_SIN_H;
            ST_SIN_H: state_next = ST_SIN_I;
            ST_SIN_I: state_next = cos_pass_reg ? ST_DQ_A : ST_SIN_A;
            ST_DQ_A:  state_next = ST_DQ_B;
            ST_DQ_B:  state_next = ST_DQ_C;
            ST_DQ_C:  state_next = ST_DQ_D;
            ST_DQ_D:  state_next = ST_DQ_E;
            ST_DQ_E:  state_next = ST_PI_A;
            ST_PI_A:  state_next = ST_PI_B;
            ST_PI_B:  state_next = ST_PI_C;
            ST_PI_C:  state_next = ST_PI_D;
            ST_PI_D:  state_next = ST_PI_E;
            ST_PI_E:  state_next = ST_PH_A;
            ST_PH_A:  state_next = ST_PH_B;
            ST_PH_B:  state_next = ST_PH_C;
            ST_PH_C:  state_next = ST_SG_A;
            ST_SG_A:  state_next = ST_SG_B;
            ST_SG_B:  state_next = ST_SG_C;
            ST_SG_C:  state_next = ST_SG_D;
            ST_SG_D:  state_next = ST_SG_E;
            ST_SG_E:  state_next = ST_SG_F;
            ST_SG_F:  state_next = ST_SG_G;
            ST_SG_G:  state_next = ST_SG_H;
            ST_SG_H:  state_next = ST_SG_I;
            ST_SG_I:  state_next = ST_SG_J;
            ST_SG_J:  state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: ready (held low in reset) and multiplier operand select
    always_comb begin
        s_tready = (state_reg == ST_IDLE) && aresetn;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_SIN_A: begin mul_a = {t32[31], t32};             mul_b = K_PARA_SQ; end
            ST_SIN_B: begin
                mul_a = {prod_lo[31], prod_lo >>> 10};
                mul_b = {t32[31], t32};
            end
            ST_SIN_C: begin mul_a = {t32[31], t32};             mul_b = K_PARA_LIN; end
            ST_SIN_F: begin
                mul_a = {y_reg[31], y_reg >>> 10};
                mul_b = {mag_reg[31], mag_reg};
            end
            ST_SIN_H: begin mul_a = {corr_reg[31], corr_reg};   mul_b = K_REFINE; end
            ST_DQ_A:  begin mul_a = {g32[31], g32};             mul_b = {s_reg[31], s_reg}; end
            ST_DQ_B:  begin mul_a = {bsh[31], bsh};             mul_b = {c_reg[31], c_reg}; end
            ST_DQ_C:  begin mul_a = {g32[31], g32};             mul_b = {c_reg[31], c_reg}; end
            ST_DQ_D:  begin mul_a = {bsh[31], bsh};             mul_b = {s_reg[31], s_reg}; end
            ST_PI_A:  begin
                mul_a = {gain_int_reg[31], gain_int_reg};
                mul_b = {qs_reg[31], qs_reg};
            end
            ST_PI_B:  begin
                mul_a = {gain_prop_reg[31], gain_prop_reg};
                mul_b = {qs_reg[31], qs_reg};
            end
            ST_PH_A:  begin mul_a = {w_reg[31], w_reg};         mul_b = DIV_RECIP; end
            ST_SG_A:  begin mul_a = {g32[31], g32};             mul_b = {wsh[31], wsh}; end
            ST_SG_C:  begin mul_a = {1'b0, absx_reg};           mul_b = DIV_RECIP; end
            ST_SG_G:  begin mul_a = {bsh[31], bsh};             mul_b = {wsh[31], wsh}; end
            ST_SG_I:  begin mul_a = {1'b0, absx_reg};           mul_b = DIV_RECIP; end
            default:  begin mul_a = '0;                         mul_b = '0; end
        endcase
    end

    // Control, configuration and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            omega_ref_reg   <= OMEGA_REF_RST;
            gain_int_reg    <= '0;
            gain_prop_reg   <= '0;
            omega_max_reg   <= OMEGA_MAX_RST;
            omega_min_reg   <= OMEGA_MIN_RST;
            phase_acc_reg   <= '0;
            pi_integral_reg <= '0;
            beta_reg        <= '0;
            sogi_one_reg    <= '0;
            sogi_two_reg    <= '0;
        end else begin
            state_reg <= state_next;

            // Output valid: set on load, cleared when the transaction completes
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Register writes; unused indexes are ignored
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_OMEGA_REF: omega_ref_reg <= cfg_wdata[30:0];
                    REG_GAIN_INT:  gain_int_reg  <= cfg_wdata;
                    REG_GAIN_PROP: gain_prop_reg <= cfg_wdata;
                    REG_OMEGA_MAX: omega_max_reg <= cfg_wdata[30:0];
                    REG_OMEGA_MIN: omega_min_reg <= cfg_wdata[30:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_PI_B: pi_integral_reg <= pi_integral_reg + prod_lo;
                ST_PH_C: begin
                    // single wrap into +-pi
                    if (ph_tmp_reg > PHASE_PI) begin
                        phase_acc_reg <= ph_tmp_reg - PHASE_TWO_PI;
                    end else if (ph_tmp_reg < -PHASE_PI) begin
                        phase_acc_reg <= ph_tmp_reg + PHASE_TWO_PI;
                    end else begin
                        phase_acc_reg <= ph_tmp_reg;
                    end
                end
                ST_SG_D: sogi_one_reg <= sogi_one_reg + quo_s;
                ST_SG_F: beta_reg     <= acc_reg - sogi_two_reg;
                ST_SG_J: sogi_two_reg <= sogi_two_reg + quo_s;
                default: ;
            endcase
        end
    end

    // Datapath working registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (out_load) begin
            m_tdata_reg <= {4'b0, c_reg[11:0], s_reg[11:0], w_reg[28:0],
                            phase_acc_reg[22:0], vd_reg};
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    g_reg        <= s_tdata[11:0];
                    th_reg       <= phase_acc_reg;
                    cos_pass_reg <= 1'b0;
                    thc_reg      <= (thc_sum > PHASE_PI) ? thc_sum - PHASE_TWO_PI : thc_sum;
                end
            end
            ST_SIN_C: sq_reg <= prod_lo;
            ST_SIN_D: y_reg  <= th_reg[23] ? prod_lo + sq_reg : prod_lo - sq_reg;
            ST_SIN_E: mag_reg <= y_reg[31] ? (neg_y >>> 10) : (y_reg >>> 10);
            ST_SIN_G: corr_reg <= (prod_lo - y_reg) >>> 10;
            ST_SIN_I: begin
                // first pass gives sine, second cosine
                if (cos_pass_reg) begin
                    c_reg <= sin_sum >>> 10;
                end else begin
                    s_reg        <= sin_sum >>> 10;
                    th_reg       <= thc_reg;
                    cos_pass_reg <= 1'b1;
                end
            end
            ST_DQ_B: acc_reg <= prod_lo;
            ST_DQ_C: vd_reg  <= acc_reg - prod_lo;
            ST_DQ_D: acc_reg <= prod_lo;
            ST_DQ_E: qs_reg  <= vq >>> 10;
            ST_PI_C: acc_reg <= pi_integral_reg + prod_lo;
            ST_PI_D: w_reg   <= $signed({1'b0, omega_ref_reg}) + acc_reg;
            ST_PI_E: begin
                // upper limit wins over lower limit
                if (w_reg > $signed({1'b0, omega_max_reg})) begin
                    w_reg <= {1'b0, omega_max_reg};
                end else if (w_reg < $signed({1'b0, omega_min_reg})) begin
                    w_reg <= {1'b0, omega_min_reg};
                end
            end
            ST_PH_B: ph_tmp_reg <= phase_acc_reg + $signed({{(24-QUO_W){1'b0}}, quo});
            ST_PH_C: neg_reg <= 1'b0;
            ST_SG_B, ST_SG_H: begin
                absx_reg <= abs_prod;
                neg_reg  <= prod_lo[31];
            end
            ST_SG_E: acc_reg <= sogi_one_reg - (g32 <<< 10);
            default: ;
        endcase
    end

    // Phase accumulator never leaves +-pi
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_acc_reg <= PHASE_PI) && (phase_acc_reg >= -PHASE_PI))
        else $error("phase accumulator out of range");

    // With ordered limits the delivered frequency lies inside them
    a_omega_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (omega_min_reg <= omega_max_reg)) |=>
        ((w_reg >= $signed({1'b0, omega_min_reg})) &&
         (w_reg <= $signed({1'b0, omega_max_reg}))))
        else $error("omega outside clamp limits");

    // Sine pass is always followed by the cosine pass
    a_cos_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIN_I && !cos_pass_reg) |=>
        (state_reg == ST_SIN_A && cos_pass_reg))
        else $error("cosine pass skipped");

    // A new result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready && state_reg == ST_OUT) |=> (state_reg == ST_OUT))
        else $error("result overwritten before transaction");

endmodule

`default_nettype wire
